>>> hdl/sqf_pkg.sv
`default_nettype none
package sqf_pkg;

  localparam int PIXEL_W     = 8;
  localparam int TERM_W      = 24;
  localparam int WQ_W        = 19;   // signed Q2.16 tap weight
  localparam int ROUND_SHIFT = 8;    // Q.16 sum to units of 1/256

  localparam longint ONE_Q  = 65536;
  localparam longint WQ_MAX = 262143;
  localparam longint WQ_MIN = -262144;
  localparam int     OUT_MAX = 8388607;
  localparam int     OUT_MIN = -8388608;

  typedef enum logic [1:0] {
    COEF_CONST,
    COEF_LINEAR,
    COEF_QUAD
  } coef_kind_t;

  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef logic signed [TERM_W-1:0] term_t;

endpackage
`default_nettype wire

>>> hdl/sqf_window.sv
`default_nettype none
module sqf_window
  import sqf_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  wire pixel_t pixel,
  input  wire logic   line_start,
  output logic        will_fire,
  output pixel_t      taps [WINDOW],
  output logic        taps_valid
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0] ONE  = FILL_W'(1);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  always_comb begin
    if (line_start) begin
      fill_next = ONE;
    end else if (fill == FULL) begin
      fill_next = FULL;
    end else begin
      fill_next = fill + ONE;
    end
    will_fire = (fill_next == FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      taps_valid <= 1'b0;
    end else begin
      taps_valid <= accept && will_fire;
      if (accept) begin
        fill <= fill_next;
      end
    end
  end

  // Shift towards the oldest tap; a line start clears the history first.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < WINDOW - 1; j++) begin
        taps[j] <= line_start ? '0 : taps[j+1];
      end
      taps[WINDOW-1] <= pixel;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sqf_mac.sv
`default_nettype none
module sqf_mac
  import sqf_pkg::*;
#(
  parameter int         WINDOW = 8,
  parameter coef_kind_t KIND   = COEF_CONST
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire pixel_t taps [WINDOW],
  output logic        out_valid,
  output term_t       term
);

  localparam int LEVELS = $clog2(WINDOW);
  localparam int NPAD   = 1 << LEVELS;
  localparam int PROD_W = WQ_W + PIXEL_W + 1;
  localparam int ACC_W  = PROD_W + LEVELS;
  localparam int RW     = (ACC_W + 1 > TERM_W + 1) ? ACC_W + 1 : TERM_W + 1;
  localparam int LAT    = LEVELS + 2;

  // Closed forms of the basis sums over u = 2i - N + 1.
  localparam longint N  = longint'(WINDOW);
  localparam longint U2 = N * (N * N - 1) / 3;
  localparam longint S4 = N * (N * N - 1) * (3 * N * N - 7) / 15;
  localparam longint VS = N * N * S4 - N * U2 * U2;

  localparam logic signed [RW-1:0] SAT_HI   = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO   = RW'(OUT_MIN);
  localparam logic signed [RW-1:0] BIAS_POS = RW'(128);
  localparam logic signed [RW-1:0] BIAS_NEG = RW'(127);

  // Heap-ordered adder tree: leaves at NPAD.., root at 1.
  logic signed [ACC_W-1:0] node [1:2*NPAD-1];
  logic [LAT-1:0]          vpipe;
  logic signed [RW-1:0]    rsum;
  logic signed [RW-1:0]    rshift;

  genvar i, k;
  for (i = 0; i < NPAD; i++) begin : g_leaf
    if (i < WINDOW) begin : g_tap
      localparam longint U   = 2 * longint'(i) - N + 1;
      localparam longint VT  = N * U * U - U2;
      localparam longint NUM = (KIND == COEF_LINEAR) ? U * N * ONE_Q :
                               (KIND == COEF_QUAD)   ? VT * N * N * N * ONE_Q :
                                                       (VS - N * U2 * VT) * ONE_Q;
      localparam longint DEN = (KIND == COEF_LINEAR) ? U2 :
                               (KIND == COEF_QUAD)   ? VS : N * VS;
      localparam longint MAG  = (NUM < 0) ? -NUM : NUM;
      localparam longint QT   = (2 * MAG + DEN) / (2 * DEN);
      localparam longint RND  = (NUM < 0) ? -QT : QT;
      localparam longint RSAT = (RND > WQ_MAX) ? WQ_MAX :
                                (RND < WQ_MIN) ? WQ_MIN : RND;
      localparam logic signed [WQ_W-1:0] WEIGHT = WQ_W'(RSAT);

      logic signed [PROD_W-1:0] prod;
      assign prod = PROD_W'($signed({1'b0, taps[i]})) * PROD_W'(WEIGHT);

      always_ff @(posedge clk) begin
        node[NPAD+i] <= ACC_W'(prod);
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node[NPAD+i] <= '0;
      end
    end
  end

  for (k = 1; k < NPAD; k++) begin : g_node
    always_ff @(posedge clk) begin
      node[k] <= node[2*k] + node[2*k+1];
    end
  end

  // Round half away from zero to 1/256, then clamp to 24 bits.
  always_comb begin
    rsum   = RW'(node[1]) + (node[1][ACC_W-1] ? BIAS_NEG : BIAS_POS);
    rshift = rsum >>> ROUND_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rshift > SAT_HI) begin
      term <= TERM_W'(SAT_HI);
    end else if (rshift < SAT_LO) begin
      term <= TERM_W'(SAT_LO);
    end else begin
      term <= TERM_W'(rshift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vpipe[LAT-1];

endmodule
`default_nettype wire

>>> hdl/sqf_fifo.sv
`default_nettype none
module sqf_fifo #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             rd_fire;

  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_fire) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_fire);
    end
  end

endmodule
`default_nettype wire

>>> hdl/sliding_quadratic_fit.sv
`default_nettype none
// Sliding degree-2 least-squares fit over a line of 8-bit pixels. The block keeps the
// last WINDOW pixels and, once the window is full, returns the fitted constant, linear
// and quadratic coefficients (x from -(WINDOW-1)/WINDOW to +(WINDOW-1)/WINDOW) in units
// of 1/256, rounded half away from zero and clamped to 24-bit signed. The per-tap
// Q2.16 weights are constants fixed at elaboration from WINDOW (3..32). A transaction
// with tuser high starts a new line: the window empties and that pixel becomes its
// first sample, so the first WINDOW-1 pixels of a line give no result. One pixel is
// taken every clock while s_tready is high; a result passes through the window register,
// the weight multipliers, one register per adder-tree level, the rounding stage and the
// output FIFO. Results queue in that small FIFO; s_tready falls only once every FIFO slot
// is promised to a result still in flight or not yet taken.
module sliding_quadratic_fit
  import sqf_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel
  input  wire logic        s_tuser,   // [0] line_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata    // [23:0] constant_term, [47:24] linear_term,
                                      // [71:48] quadratic_term
);

  localparam int LEVELS     = $clog2(WINDOW);
  localparam int LATENCY    = LEVELS + 3;
  localparam int FIFO_DEPTH = 1 << $clog2(LATENCY + 2);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int DATA_W     = 3 * TERM_W;

  logic              in_fire;
  logic              out_fire;
  logic              will_fire;
  pixel_t            taps [WINDOW];
  logic              taps_valid;
  logic              term_valid;
  logic              lin_valid;
  logic              quad_valid;
  logic              fifo_wr;
  term_t             c_term;
  term_t             l_term;
  term_t             q_term;
  logic [CNT_W-1:0]  pending;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // Credit: count results promised but not yet taken; hold off input when all slots owed.
  assign s_tready = (pending < CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(in_fire && will_fire) - CNT_W'(out_fire);
    end
  end

  sqf_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_fire),
    .pixel      (s_tdata),
    .line_start (s_tuser),
    .will_fire  (will_fire),
    .taps       (taps),
    .taps_valid (taps_valid)
  );

  // One weighted sum per coefficient; all three run in lock step.
  sqf_mac #(
    .WINDOW (WINDOW),
    .KIND   (COEF_CONST)
  ) u_mac_const (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (taps_valid),
    .taps      (taps),
    .out_valid (term_valid),
    .term      (c_term)
  );

  sqf_mac #(
    .WINDOW (WINDOW),
    .KIND   (COEF_LINEAR)
  ) u_mac_linear (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (taps_valid),
    .taps      (taps),
    .out_valid (lin_valid),
    .term      (l_term)
  );

  sqf_mac #(
    .WINDOW (WINDOW),
    .KIND   (COEF_QUAD)
  ) u_mac_quad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (taps_valid),
    .taps      (taps),
    .out_valid (quad_valid),
    .term      (q_term)
  );

  assign fifo_wr = term_valid && lin_valid && quad_valid;

  sqf_fifo #(
    .WIDTH (DATA_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fifo_wr),
    .wr_data  ({q_term, l_term, c_term}),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (m_tdata)
  );

endmodule
`default_nettype wire

>>> tb/tb_sliding_quadratic_fit.sv
`default_nettype none
module tb_sliding_quadratic_fit;
  import sqf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = 8;
  // Below this many pixels still to send, both sides stop idling.
  localparam int CALM_TAIL = 50;

  typedef struct {
    pixel_t pixel;
    bit     line_start;
    bit     hold_for_drain;  // send only once every expected fit has arrived
  } pixel_txn_t;

  typedef struct packed {
    term_t constant_term;
    term_t linear_term;
    term_t quadratic_term;
  } fit_terms_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] pixel
  logic        s_tuser = 1'b0; // [0] line_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [23:0] constant_term, [47:24] linear_term,
                               // [71:48] quadratic_term

  // Pixels waiting to be sent, and fits waiting to come back, oldest first.
  pixel_txn_t pixel_backlog[$];
  fit_terms_t fit_expected[$];

  // Predictor state: a copy of the window and its fill count.
  pixel_t fit_window[WINDOW];
  int     fit_fill;

  // Q2.16 tap weights, tap 0 being the oldest pixel.
  longint wt_const[WINDOW];
  longint wt_lin[WINDOW];
  longint wt_quad[WINDOW];

  int mismatch_count = 0;
  int gap_left = 0;
  int stall_left = 0;

  sliding_quadratic_fit #(.WINDOW(WINDOW)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Divide and round half away from zero, then clamp to the Q2.16 range.
  function automatic longint round_q216(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > WQ_MAX) q = WQ_MAX;
    if (q < WQ_MIN) q = WQ_MIN;
    return q;
  endfunction

  // Scale a Q.16 sum down to units of 1/256, rounding half away from zero,
  // and clamp to the 24-bit signed range.
  function automatic term_t to_term(input longint acc);
    longint mag;
    longint q;
    mag = (acc < 0) ? -acc : acc;
    q = (mag + (longint'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (acc < 0) q = -q;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    return term_t'(q);
  endfunction

  // Advance the predicted window by one pixel; return 1 when a fit is due.
  function automatic bit advance_window(input pixel_t pix, input bit line_start,
                                        output fit_terms_t fit);
    longint a0;
    longint a1;
    longint a2;
    a0 = 0;
    a1 = 0;
    a2 = 0;
    fit = '{default: '0};
    // A line start empties the window before the pixel enters.
    if (line_start) begin
      foreach (fit_window[k]) fit_window[k] = '0;
      fit_fill = 0;
    end
    for (int k = 0; k < WINDOW - 1; k++) fit_window[k] = fit_window[k + 1];
    fit_window[WINDOW - 1] = pix;
    if (fit_fill < WINDOW) fit_fill++;
    if (fit_fill < WINDOW) return 1'b0;
    for (int k = 0; k < WINDOW; k++) begin
      a0 += wt_const[k] * longint'(fit_window[k]);
      a1 += wt_lin[k] * longint'(fit_window[k]);
      a2 += wt_quad[k] * longint'(fit_window[k]);
    end
    fit.constant_term  = to_term(a0);
    fit.linear_term    = to_term(a1);
    fit.quadratic_term = to_term(a2);
    return 1'b1;
  endfunction

  task automatic queue_pixel(input int pix, input bit line_start, input bit hold);
    pixel_txn_t txn;
    txn.pixel          = pixel_t'(pix);
    txn.line_start     = line_start;
    txn.hold_for_drain = hold;
    pixel_backlog.push_back(txn);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build the tap weights, queue every pixel, release reset, then wait for
  // the backlog and the expected fits to run dry.
  initial begin
    longint n;
    longint u;
    longint v;
    longint u2sum;
    longint vsum;
    int     line_len;
    int     style;
    int     base;
    int     slope;
    int     curve;
    int     val;
    bit     ls;

    // Orthogonal basis over the taps: u is odd-symmetric about the centre,
    // v is the even part left after removing the mean of u squared.
    n = WINDOW;
    u2sum = 0;
    vsum = 0;
    for (int k = 0; k < WINDOW; k++) begin
      u = 2 * k - n + 1;
      u2sum += u * u;
    end
    for (int k = 0; k < WINDOW; k++) begin
      u = 2 * k - n + 1;
      v = n * u * u - u2sum;
      vsum += v * v;
    end
    for (int k = 0; k < WINDOW; k++) begin
      u = 2 * k - n + 1;
      v = n * u * u - u2sum;
      wt_lin[k]   = round_q216(u * n * ONE_Q, u2sum);
      wt_quad[k]  = round_q216(v * n * n * n * ONE_Q, vsum);
      wt_const[k] = round_q216((vsum - n * u2sum * v) * ONE_Q, n * vsum);
    end
    foreach (fit_window[k]) fit_window[k] = '0;
    fit_fill = 0;

    // Directed part. Fill from the reset state without a line start.
    for (int k = 0; k < WINDOW; k++) queue_pixel(0, 1'b0, 1'b0);
    // Full-scale pixels slide through a full window.
    for (int k = 0; k < WINDOW; k++) queue_pixel(255, 1'b0, 1'b0);
    // Hold this line start back until the pipeline has drained.
    queue_pixel(255, 1'b1, 1'b1);
    queue_pixel(0, 1'b0, 1'b0);
    queue_pixel(255, 1'b0, 1'b0);
    queue_pixel(0, 1'b0, 1'b0);
    // Line start on a partly filled window.
    queue_pixel(128, 1'b1, 1'b0);
    queue_pixel(16, 1'b0, 1'b0);
    queue_pixel(64, 1'b0, 1'b0);
    queue_pixel(200, 1'b0, 1'b0);

    // Random part: mostly whole lines, some cut short, some with stray
    // line starts, with content that is noisy, extreme, sloped or curved.
    while (pixel_backlog.size() < 420) begin
      line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, WINDOW - 1)
                                             : $urandom_range(WINDOW, 5 * WINDOW);
      style = $urandom_range(0, 3);
      base  = $urandom_range(0, 255);
      slope = $urandom_range(0, 40) - 20;
      curve = $urandom_range(0, 16) - 8;
      for (int j = 0; j < line_len; j++) begin
        case (style)
          0: val = $urandom_range(0, 255);
          1: val = $urandom_range(0, 1) ? 255 : 0;
          2: val = base + slope * j;
          default: val = base + curve * (j - line_len / 2) * (j - line_len / 2);
        endcase
        if (val < 0) val = 0;
        if (val > 255) val = 255;
        if (j == 0) ls = ($urandom_range(0, 7) != 0);
        else ls = ($urandom_range(0, 39) == 0);
        queue_pixel(val, ls, (j == 0) && ($urandom_range(0, 29) == 0));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pixel_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (fit_expected.size() != 0) @(posedge clk);
    // Let any stray output surface before the verdict.
    repeat (4 * ($clog2(WINDOW) + 4)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sliding_quadratic_fit] OK");
    end else begin
      $display("[sliding_quadratic_fit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[sliding_quadratic_fit] ERROR");
    $finish;
  end

  // Pixel driver: predict each accepted transaction, hold data while the
  // block stalls, and idle in random bursts outside the calm tail.
  always @(posedge clk) begin : drive_pixels
    pixel_txn_t txn;
    fit_terms_t fit;
    bit         go;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        txn = pixel_backlog.pop_front();
        if (advance_window(txn.pixel, txn.line_start, fit)) fit_expected.push_back(fit);
      end
      if (!(s_tvalid && !s_tready)) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_backlog.size() != 0 &&
                     !(pixel_backlog[0].hold_for_drain && fit_expected.size() != 0)) begin
          if (pixel_backlog.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 13);
          end else begin
            go = 1'b1;
            s_tdata <= pixel_backlog[0].pixel;
            s_tuser <= pixel_backlog[0].line_start;
          end
        end
        s_tvalid <= go;
      end
    end
  end

  // Fit monitor: compare each result transaction with the oldest expected
  // fit, and stall the output in random bursts outside the calm tail.
  always @(posedge clk) begin : watch_fits
    fit_terms_t want;
    fit_terms_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.constant_term  = m_tdata[23:0];
        got.linear_term    = m_tdata[47:24];
        got.quadratic_term = m_tdata[71:48];
        if (fit_expected.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected fit: c0=%0d c1=%0d c2=%0d", got.constant_term,
                     got.linear_term, got.quadratic_term);
          mismatch_count++;
        end else begin
          want = fit_expected.pop_front();
          if (got != want) begin
            if (mismatch_count < 10)
              $display("fit mismatch: expected c0=%0d c1=%0d c2=%0d, got c0=%0d c1=%0d c2=%0d",
                       want.constant_term, want.linear_term, want.quadratic_term,
                       got.constant_term, got.linear_term, got.quadratic_term);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (pixel_backlog.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
